### rtl/prs_pkg.sv
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types and constants for the page replacement simulator.
// ----------------------------------------------------------------------------
package prs_pkg;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int PAGE_IN_W   = 8;
  localparam int POS_W       = 6;
  localparam int RPAGE_W     = 8;
  localparam int SLOT_OUT_W  = 3;
  localparam int FAULT_W     = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 4;
  localparam int POLICY_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 1'b1;

  // any other policy code runs as FIFO
  localparam logic [POLICY_W-1:0] POL_OPT = 2'd1;
  localparam logic [POLICY_W-1:0] POL_LRU = 2'd2;

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_READ,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_CHK
  } prs_state_e;

  typedef struct packed {
    logic clear;
    logic write;
    logic seen_clr;
    logic seen_upd;
  } prs_frm_ctrl_t;

  typedef struct packed {
    logic hit;
    logic all_seen;
  } prs_frm_stat_t;

endpackage

### rtl/prs_ref_mem.sv
// ----------------------------------------------------------------------------
// prs_ref_mem
// Reference string store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module prs_ref_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/prs_frame_tbl.sv
// ----------------------------------------------------------------------------
// prs_frame_tbl
// Frame table: resident pages, valid and seen bits, match and pick encoders.
// ----------------------------------------------------------------------------
module prs_frame_tbl #(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 8,
  localparam int SW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  localparam int FW = $clog2(MAX_FRAMES + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  prs_pkg::prs_frm_ctrl_t ctrl_i,
  input  logic [FW-1:0]          fc_i,
  input  logic [SW-1:0]          wr_slot_i,
  input  logic [PAGE_BITS-1:0]   wr_page_i,
  input  logic [PAGE_BITS-1:0]   cmp_page_i,
  output prs_pkg::prs_frm_stat_t stat_o,
  output logic [SW-1:0]          match_slot_o,
  output logic [SW-1:0]          unseen_slot_o
);
  import prs_pkg::*;

  logic [PAGE_BITS-1:0]  page_q [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_q, seen_q, seen_d, match, inuse;

  always_comb begin
    for (int t = 0; t < MAX_FRAMES; t++) begin
      match[t] = valid_q[t] && (page_q[t] == cmp_page_i);
      inuse[t] = FW'(t) < fc_i;
    end
    seen_d = (ctrl_i.seen_clr ? '0 : seen_q) | (ctrl_i.seen_upd ? match : '0);
    stat_o.hit      = |(match & inuse);
    stat_o.all_seen = &(seen_d | ~inuse);
    match_slot_o  = '0;
    unseen_slot_o = '0;
    for (int t = MAX_FRAMES - 1; t >= 0; t--) begin
      if (match[t]) begin
        match_slot_o = SW'(t);
      end
      if (!seen_d[t] && inuse[t]) begin
        unseen_slot_o = SW'(t);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      seen_q  <= '0;
    end else begin
      seen_q <= seen_d;
      if (ctrl_i.clear) begin
        valid_q <= '0;
      end else if (ctrl_i.write) begin
        valid_q[wr_slot_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.write) begin
      page_q[wr_slot_i] <= wr_page_i;
    end
  end

endmodule

### rtl/page_replacement_simulator.sv
// ----------------------------------------------------------------------------
// page_replacement_simulator
// Loads a page reference string, then replays it under FIFO, OPT or LRU.
// ----------------------------------------------------------------------------
// Loading: one reference word per cycle. The final word (tlast, or a full
// store) starts the replay; no input is taken until its last result is formed.
// Replay: a set-up state, then a read and a check state per reference, plus a read
// and a check per scanned reference when OPT or LRU evicts (up to MAX_REFS-1) through
// one read port. Results leave through an output register; a stalled sink stalls it.
// Async active-low reset clears control state; store and frame pages are not reset.
module page_replacement_simulator #(
  parameter int MAX_REFS   = 64,
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [prs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [prs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [prs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // page[7:0]
  input  logic                              s_axis_tlast,  // last
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // position[5:0], ref_page[13:6], hit[14], slot[17:15], fault_count[24:18]
  output logic [prs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast   // end_of_run
);
  import prs_pkg::*;

  localparam int IW = $clog2(MAX_REFS);
  localparam int CW = $clog2(MAX_REFS + 1);
  localparam int SW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FW = $clog2(MAX_FRAMES + 1);

  prs_state_e state_q, state_d;
  logic [POLICY_W-1:0]   policy_q;
  logic [CFG_DATA_W-1:0] frame_count_q;
  logic [CW-1:0] cnt_q, cnt_d, n_q, n_d, faults_q, faults_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d;
  logic [FW-1:0] fc_q, fc_d, fill_q, fill_d, fc_new;
  logic [SW-1:0] fifo_q, fifo_d;
  logic [PAGE_BITS-1:0] cur_pg_q, cur_pg_d, page_now, rd_data;
  logic out_valid_q, out_valid_d, out_free;

  logic [POS_W-1:0]      out_pos_q;
  logic [RPAGE_W-1:0]    out_page_q;
  logic                  out_hit_q;
  logic [SLOT_OUT_W-1:0] out_slot_q;
  logic [FAULT_W-1:0]    out_faults_q;
  logic                  out_eor_q;

  logic          mem_we, rd_en, commit, hit_flag, i_last, opt_mode, use_fill, scan_end;
  logic [IW-1:0] rd_addr;
  logic [SW-1:0] slot_sel, match_slot, unseen_slot;
  prs_frm_ctrl_t frm_ctrl;
  prs_frm_stat_t frm_stat;

  prs_ref_mem #(
    .DEPTH (MAX_REFS),
    .AW    (IW),
    .DW    (PAGE_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i (PAGE_BITS'(s_axis_tdata[PAGE_IN_W-1:0])),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  prs_frame_tbl #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_frames (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (frm_ctrl),
    .fc_i          (fc_q),
    .wr_slot_i     (slot_sel),
    .wr_page_i     (page_now),
    .cmp_page_i    (rd_data),
    .stat_o        (frm_stat),
    .match_slot_o  (match_slot),
    .unseen_slot_o (unseen_slot)
  );

  always_comb begin
    if (frame_count_q == '0) begin
      fc_new = FW'(1);
    end else if (32'(frame_count_q) > MAX_FRAMES) begin
      fc_new = FW'(MAX_FRAMES);
    end else begin
      fc_new = FW'(frame_count_q);
    end
  end

  assign opt_mode = (policy_q == POL_OPT);
  assign use_fill = policy_q inside {POL_OPT, POL_LRU};
  assign i_last   = (CW'(i_q) == n_q - CW'(1));
  assign scan_end = opt_mode ? (CW'(j_q) == n_q - CW'(1)) : (j_q == '0);
  assign page_now = (state_q == S_CHECK) ? rd_data : cur_pg_q;
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    i_d         = i_q;
    j_d         = j_q;
    fc_d        = fc_q;
    fill_d      = fill_q;
    fifo_d      = fifo_q;
    faults_d    = faults_q;
    cur_pg_d    = cur_pg_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    s_axis_tready = 1'b0;
    mem_we   = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = i_q;
    frm_ctrl = '0;
    commit   = 1'b0;
    hit_flag = 1'b0;
    slot_sel = '0;

    case (state_q)
      S_LOAD: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + CW'(1);
          if (s_axis_tlast || cnt_q == CW'(MAX_REFS - 1)) begin
            n_d     = cnt_q + CW'(1);
            state_d = S_START;
          end
        end
      end
      S_START: begin
        frm_ctrl.clear = 1'b1;
        fc_d     = fc_new;
        fill_d   = '0;
        fifo_d   = '0;
        faults_d = '0;
        i_d      = '0;
        cnt_d    = '0;
        state_d  = S_READ;
      end
      S_READ: begin
        rd_en   = 1'b1;
        rd_addr = i_q;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        cur_pg_d = rd_data;
        if (frm_stat.hit) begin
          hit_flag = 1'b1;
          commit   = out_free;
        end else if (use_fill) begin
          if (fill_q < fc_q) begin
            slot_sel = SW'(fill_q);
            commit   = out_free;
            if (out_free) begin
              fill_d = fill_q + FW'(1);
            end
          end else if (opt_mode ? i_last : (i_q == '0)) begin
            frm_ctrl.seen_clr = 1'b1;
            slot_sel = unseen_slot;
            commit   = out_free;
          end else begin
            frm_ctrl.seen_clr = 1'b1;
            j_d     = opt_mode ? i_q + IW'(1) : i_q - IW'(1);
            state_d = S_SCAN_RD;
          end
        end else begin
          slot_sel = fifo_q;
          commit   = out_free;
          if (out_free) begin
            fifo_d = (FW'(fifo_q) + FW'(1) == fc_q) ? '0 : fifo_q + SW'(1);
          end
        end
      end
      S_SCAN_RD: begin
        rd_en   = 1'b1;
        rd_addr = j_q;
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        frm_ctrl.seen_upd = 1'b1;
        if (frm_stat.all_seen) begin
          slot_sel = match_slot;
          commit   = out_free;
        end else if (scan_end) begin
          slot_sel = unseen_slot;
          commit   = out_free;
        end else begin
          j_d     = opt_mode ? j_q + IW'(1) : j_q - IW'(1);
          state_d = S_SCAN_RD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase

    if (commit) begin
      out_valid_d = 1'b1;
      if (!hit_flag) begin
        frm_ctrl.write = 1'b1;
        faults_d = faults_q + CW'(1);
      end
      if (i_last) begin
        state_d = S_LOAD;
      end else begin
        i_d     = i_q + IW'(1);
        state_d = S_READ;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_LOAD;
      policy_q      <= '0;
      frame_count_q <= CFG_DATA_W'(3);
      cnt_q         <= '0;
      n_q           <= '0;
      i_q           <= '0;
      j_q           <= '0;
      fc_q          <= FW'(1);
      fill_q        <= '0;
      fifo_q        <= '0;
      faults_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      i_q         <= i_d;
      j_q         <= j_d;
      fc_q        <= fc_d;
      fill_q      <= fill_d;
      fifo_q      <= fifo_d;
      faults_q    <= faults_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_POLICY: policy_q      <= cfg_data_i[POLICY_W-1:0];
          REG_FRAMES: frame_count_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_pg_q <= cur_pg_d;
    if (commit) begin
      out_pos_q    <= POS_W'(i_q);
      out_page_q   <= RPAGE_W'(page_now);
      out_hit_q    <= hit_flag;
      out_slot_q   <= hit_flag ? '0 : SLOT_OUT_W'(slot_sel);
      out_faults_q <= FAULT_W'(faults_d);
      out_eor_q    <= i_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_eor_q;
  assign m_axis_tdata  = {7'd0, out_faults_q, out_slot_q, out_hit_q, out_page_q, out_pos_q};

  a_fault_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (8'(out_faults_q) <= 8'(out_pos_q) + 8'd1))
    else $error("fault count exceeds references replayed");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frm_ctrl.write |-> (FW'(slot_sel) < fc_q))
    else $error("frame write outside frames in use");

  a_store_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> (32'(cnt_q) < MAX_REFS))
    else $error("reference store overrun while loading");

endmodule

### tb/sv/tb_page_replacement_simulator.sv
// ----------------------------------------------------------------------------
// tb_page_replacement_simulator
// Streams page reference strings into the simulator under every policy and a
// range of frame counts, with random gaps on the input and random stalls on
// the output. A local model replays each string and every result word is
// checked field by field, in order, against it.
// ----------------------------------------------------------------------------
module tb_page_replacement_simulator;
  timeunit 1ns;
  timeprecision 1ps;

  import prs_pkg::*;

  localparam int MAX_REFS   = 64;
  localparam int MAX_FRAMES = 8;
  localparam int RAND_WORDS = 230;
  localparam int IDLE_TAIL  = 12;
  localparam int CYCLE_LIMIT = 500000;

  localparam logic [POLICY_W-1:0] POL_FIFO     = 2'd0;
  localparam logic [POLICY_W-1:0] POL_FIFO_ALT = 2'd3;

  typedef struct packed {
    logic [7:0] page;
    logic       last;
  } page_word_t;

  typedef struct packed {
    logic [5:0] position;
    logic [7:0] ref_page;
    logic       hit;
    logic [2:0] slot;
    logic [6:0] fault_count;
    logic       end_of_run;
  } replay_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // page[7:0]
  logic                   s_axis_tlast  = 1'b0; // last
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // position[5:0], ref_page[13:6], hit[14], slot[17:15], fault_count[24:18]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;  // end_of_run

  page_replacement_simulator i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  logic [POLICY_W-1:0] cur_policy = POL_FIFO;
  logic [3:0]          cur_frames = 4'd3;
  logic [7:0]          string_mem [MAX_REFS];
  int                  loaded_cnt = 0;
  logic [7:0]          frame_page [MAX_FRAMES];
  bit                  frame_live [MAX_FRAMES];

  page_word_t     page_words [$];
  replay_result_t due_results [$];

  int  queued_cnt   = 0;
  int  accepted_cnt = 0;
  int  checked_cnt  = 0;
  int  string_cnt   = 0;
  int  config_cnt   = 0;
  int  fail_cnt     = 0;
  int  cycle_cnt    = 0;
  bit  in_taken     = 1'b0;
  bit  out_taken    = 1'b0;
  bit  in_quiet     = 1'b0;
  bit  out_quiet    = 1'b0;
  int  in_gap       = 0;
  int  out_stall    = 0;

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 11);
  endfunction

  // replays the loaded string and queues one expected word per reference
  task automatic replay_string();
    int fc, fill, fifo_at, faults, slot, chosen, best, best_use, use_at, cnt;
    bit hit, found;
    bit seen [MAX_FRAMES];
    logic [7:0] pg;
    replay_result_t r;
    fc = cur_frames;
    if (fc == 0) fc = 1;
    if (fc > MAX_FRAMES) fc = MAX_FRAMES;
    foreach (frame_live[t]) frame_live[t] = 1'b0;
    fill = 0;
    fifo_at = 0;
    faults = 0;
    for (int i = 0; i < loaded_cnt; i++) begin
      pg = string_mem[i];
      hit = 1'b0;
      slot = 0;
      for (int t = 0; t < fc; t++)
        if (frame_live[t] && frame_page[t] == pg) hit = 1'b1;
      if (!hit) begin
        if (cur_policy == POL_OPT || cur_policy == POL_LRU) begin
          if (fill < fc) begin
            slot = fill;
            fill++;
          end else if (cur_policy == POL_OPT) begin
            // evict the frame needed furthest ahead, or the first never needed
            foreach (seen[t]) seen[t] = 1'b0;
            chosen = -1;
            for (int j = i + 1; j < loaded_cnt && chosen < 0; j++) begin
              for (int t = 0; t < fc; t++)
                if (frame_live[t] && frame_page[t] == string_mem[j]) seen[t] = 1'b1;
              cnt = 0;
              for (int t = 0; t < fc; t++)
                if (seen[t]) cnt++;
              if (cnt == fc)
                for (int t = 0; t < fc; t++)
                  if (chosen < 0 && frame_live[t] && frame_page[t] == string_mem[j])
                    chosen = t;
              if (chosen < 0 && j == loaded_cnt - 1)
                for (int t = 0; t < fc; t++)
                  if (chosen < 0 && !seen[t]) chosen = t;
            end
            slot = (chosen < 0) ? 0 : chosen;
          end else begin
            chosen = -1;
            best = 0;
            best_use = i;
            for (int t = 0; t < fc && chosen < 0; t++) begin
              if (!frame_live[t]) begin
                chosen = t;
              end else begin
                found = 1'b0;
                use_at = 0;
                for (int j = i; j > 0 && !found; j--)
                  if (string_mem[j-1] == frame_page[t]) begin
                    found = 1'b1;
                    use_at = j - 1;
                  end
                if (!found) begin
                  chosen = t;
                end else if (use_at < best_use) begin
                  best_use = use_at;
                  best = t;
                end
              end
            end
            slot = (chosen < 0) ? best : chosen;
          end
        end else begin
          slot = fifo_at % fc;
          fifo_at = (slot + 1) % fc;
        end
        frame_page[slot] = pg;
        frame_live[slot] = 1'b1;
        faults++;
      end
      r.position    = 6'(i);
      r.ref_page    = pg;
      r.hit         = hit;
      r.slot        = 3'(slot);
      r.fault_count = 7'(faults);
      r.end_of_run  = (i == loaded_cnt - 1);
      due_results.push_back(r);
    end
    loaded_cnt = 0;
    string_cnt++;
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  // sample both handshakes, feed the model, check result words
  always @(posedge clk_i) begin
    replay_result_t r;
    cycle_cnt++;
    in_taken  = rst_ni && s_axis_tvalid && s_axis_tready;
    out_taken = rst_ni && m_axis_tvalid && m_axis_tready;
    if (in_taken) begin
      accepted_cnt++;
      if (loaded_cnt < MAX_REFS) begin
        string_mem[loaded_cnt] = s_axis_tdata;
        loaded_cnt++;
      end
      if (s_axis_tlast || loaded_cnt >= MAX_REFS) replay_string();
    end
    if (out_taken) begin
      if (due_results.size() == 0) begin
        $error("result word with none expected: tdata %h tlast %b", m_axis_tdata,
               m_axis_tlast);
        fail_cnt++;
      end else begin
        r = due_results.pop_front();
        checked_cnt++;
        check_field("position", r.position, m_axis_tdata[5:0]);
        check_field("ref_page", r.ref_page, m_axis_tdata[13:6]);
        check_field("hit", r.hit, m_axis_tdata[14]);
        check_field("slot", r.slot, m_axis_tdata[17:15]);
        check_field("fault_count", r.fault_count, m_axis_tdata[24:18]);
        check_field("end_of_run", r.end_of_run, m_axis_tlast);
        check_field("tdata padding", 0, m_axis_tdata[OUT_TDATA_W-1:25]);
      end
    end
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_cnt,
               due_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // input side driver
  always @(negedge clk_i) begin
    page_word_t w;
    if (!rst_ni || (s_axis_tvalid && !in_taken)) begin
    end else if (in_gap > 0) begin
      s_axis_tvalid <= 1'b0;
      in_gap--;
    end else if (page_words.size() > 0) begin
      w = page_words.pop_front();
      s_axis_tdata  <= w.page;
      s_axis_tlast  <= w.last;
      s_axis_tvalid <= 1'b1;
      if ($urandom_range(0, 15) == 0) in_quiet = !in_quiet;
      in_gap = draw_wait(in_quiet);
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // output side stalls
  always @(negedge clk_i) begin
    if (out_taken) begin
      if ($urandom_range(0, 15) == 0) out_quiet = !out_quiet;
      out_stall = draw_wait(out_quiet);
    end
    if (out_stall > 0) begin
      m_axis_tready <= 1'b0;
      out_stall--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic push_word(logic [7:0] page, logic last);
    page_words.push_back('{page: page, last: last});
    queued_cnt++;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (accepted_cnt != queued_cnt || due_results.size() != 0);
    repeat (IDLE_TAIL) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    if (idx == REG_POLICY) cur_policy = data[POLICY_W-1:0];
    else cur_frames = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_mode(logic [POLICY_W-1:0] pol, logic [3:0] frames);
    wait_idle();
    write_reg(REG_POLICY, CFG_DATA_W'(pol));
    write_reg(REG_FRAMES, frames);
    config_cnt++;
  endtask

  // random string: pages mostly from a small pool so that hits occur
  task automatic push_string(int len, bit close_last);
    logic [7:0] pool [12];
    int pool_n;
    logic [7:0] pg;
    pool_n = $urandom_range(1, 12);
    foreach (pool[k]) pool[k] = 8'($urandom_range(0, 255));
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 7) == 0) pg = 8'($urandom_range(0, 255));
      else pg = pool[$urandom_range(0, pool_n - 1)];
      push_word(pg, (k == len - 1) ? close_last : 1'($urandom_range(0, 1) & 0));
    end
  endtask

  initial begin
    logic [POLICY_W-1:0] pol;
    logic [3:0] frames;
    int len;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // textbook FIFO string, frames 3
    set_mode(POL_FIFO, 4'd3);
    push_word(8'd7, 1'b0); push_word(8'd0, 1'b0); push_word(8'd1, 1'b0);
    push_word(8'd2, 1'b0); push_word(8'd0, 1'b0); push_word(8'd3, 1'b0);
    push_word(8'd0, 1'b0); push_word(8'd4, 1'b1);
    // optimal with a fault on the final reference while frames are full
    set_mode(POL_OPT, 4'd3);
    push_word(8'd1, 1'b0); push_word(8'd2, 1'b0); push_word(8'd3, 1'b0);
    push_word(8'd9, 1'b1);
    // LRU over two frames, page extremes
    set_mode(POL_LRU, 4'd2);
    push_word(8'd0, 1'b0); push_word(8'd255, 1'b0); push_word(8'd0, 1'b0);
    push_word(8'd128, 1'b0); push_word(8'd255, 1'b1);
    // spare policy code, frame count zero
    set_mode(POL_FIFO_ALT, 4'd0);
    push_word(8'd170, 1'b0); push_word(8'd85, 1'b0); push_word(8'd170, 1'b1);
    // frame count above the maximum
    set_mode(POL_OPT, 4'd15);
    push_word(8'd0, 1'b0); push_word(8'd1, 1'b0); push_word(8'd2, 1'b1);

    // random strings; the first fills the store without tlast
    set_mode(POL_LRU, 4'd8);
    push_string(MAX_REFS, 1'b0);
    while (queued_cnt < RAND_WORDS - 12) begin
      if ($urandom_range(0, 1) == 0) begin
        pol = ($urandom_range(0, 7) == 0) ? POL_FIFO_ALT : 2'($urandom_range(0, 2));
        frames = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, 8));
        set_mode(pol, frames);
      end
      if ($urandom_range(0, 9) == 0) begin
        push_string(MAX_REFS, 1'($urandom_range(0, 1)));
      end else begin
        len = $urandom_range(1, 14);
        push_string(len, 1'b1);
      end
    end
    set_mode(POL_FIFO, 4'd1);
    push_string(6, 1'b1);
    wait_idle();

    $display("%0d reference words in %0d strings over %0d settings, %0d results checked",
             accepted_cnt, string_cnt, config_cnt, checked_cnt);
    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
rtl/prs_pkg.sv
rtl/prs_ref_mem.sv
rtl/prs_frame_tbl.sv
rtl/page_replacement_simulator.sv
tb/sv/tb_page_replacement_simulator.sv
